// ===== sv/kmer_clump_finder_macros.svh =====
// assertion macros used by kcf_ctrl of the clump finder rtl
// no dependencies; included by kcf_ctrl, the only file that carries concurrent assertions
`ifndef KMER_CLUMP_FINDER_MACROS_SVH
`define KMER_CLUMP_FINDER_MACROS_SVH

// same-cycle implication
`define KCF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmer_clump_finder: assertion failed");

// next-cycle implication
`define KCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmer_clump_finder: assertion failed");

`endif

// ===== sv/kcf_pkg.sv =====
// shared types and constants for the k-mer clump finder
// no dependencies; used by the rsp and csr interfaces, kcf_csr, kcf_ctrl, the top and the testbench
package kcf_pkg;

   localparam int KMER_MAX_DEF   = 9;
   localparam int WINDOW_MAX_DEF = 1024;

   localparam int KLEN_W     = 4;
   localparam int WLEN_W     = 11;
   localparam int THR_W      = 11;
   localparam int CNT_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd9;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd500;
   localparam logic [THR_W-1:0]  THR_RESET  = 11'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KMER_LENGTH   = 2'd0,
      CSR_WINDOW_LENGTH = 2'd1,
      CSR_THRESHOLD     = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_COMMIT,
      ST_MARK
   } state_type;

   typedef struct packed {
      logic [KLEN_W-1:0] kmer_length;
      logic [WLEN_W-1:0] window_length;
      logic [THR_W-1:0]  threshold;
   } cfg_type;

endpackage

// ===== sv/kcf_req_if.sv =====
// input channel of the clump finder: one dna base per item
// depends on nothing
interface kcf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] base;
   logic       last_base;

   modport source (output valid, base, last_base, input ready);
   modport sink   (input valid, base, last_base, output ready);
endinterface

// ===== sv/kcf_rsp_if.sv =====
// result channel of the clump finder: clump k-mer reports and end marker
// depends on kcf_pkg for the default k-mer width
interface kcf_rsp_if #(
   parameter int KW = 2 * kcf_pkg::KMER_MAX_DEF
);
   logic          valid;
   logic          ready;
   logic [KW-1:0] clump_kmer;
   logic          kmer_valid;
   logic          end_of_sequence;

   modport source (output valid, clump_kmer, kmer_valid, end_of_sequence, input ready);
   modport sink   (input valid, clump_kmer, kmer_valid, end_of_sequence, output ready);
endinterface

// ===== sv/kcf_csr_if.sv =====
// register write channel of the clump finder
// depends on kcf_pkg for index and data widths
interface kcf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [kcf_pkg::CSR_IDX_W-1:0]    index;
   logic [kcf_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/kcf_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module kcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/kcf_csr.sv =====
// configuration registers of the clump finder
// depends on kcf_pkg and kcf_csr_if
module kcf_csr (
   input  logic             clock,
   input  logic             reset,
   kcf_csr_if.sink          csr_ch,
   output kcf_pkg::cfg_type cfg
);

   kcf_pkg::cfg_type cfg_ff;
   kcf_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (kcf_pkg::csr_idx_type'(csr_ch.index))
            kcf_pkg::CSR_KMER_LENGTH: begin
               cfg_in.kmer_length = csr_ch.data[kcf_pkg::KLEN_W-1:0];
            end
            kcf_pkg::CSR_WINDOW_LENGTH: begin
               cfg_in.window_length = csr_ch.data[kcf_pkg::WLEN_W-1:0];
            end
            kcf_pkg::CSR_THRESHOLD: begin
               cfg_in.threshold = csr_ch.data[kcf_pkg::THR_W-1:0];
            end
            default: begin
               // writes beyond the register list are dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kmer_length   <= kcf_pkg::KLEN_RESET;
         cfg_ff.window_length <= kcf_pkg::WLEN_RESET;
         cfg_ff.threshold     <= kcf_pkg::THR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/kcf_ctrl.sv =====
// sequencer and datapath of the clump finder: k-mer shift register, window
// position, read-modify-write of the count memory, result register
// depends on kcf_pkg, kcf_req_if, kcf_rsp_if and the assertion macros
`include "kmer_clump_finder_macros.svh"

module kcf_ctrl #(
   parameter int KMER_MAX   = kcf_pkg::KMER_MAX_DEF,
   parameter int WINDOW_MAX = kcf_pkg::WINDOW_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kcf_pkg::cfg_type              cfg,
   kcf_req_if.sink                       req,
   kcf_rsp_if.source                     rsp,
   output logic                          hist_wr_en,
   output logic [$clog2(WINDOW_MAX)-1:0] hist_wr_addr,
   output logic [2*KMER_MAX-1:0]         hist_wr_data,
   output logic                          hist_rd_en,
   output logic [$clog2(WINDOW_MAX)-1:0] hist_rd_addr,
   input  logic [2*KMER_MAX-1:0]         hist_rd_data,
   output logic                          cnt_wr_en,
   output logic [2*KMER_MAX-1:0]         cnt_wr_addr,
   output logic [kcf_pkg::CNT_W:0]       cnt_wr_data,
   output logic                          cnt_rd_en,
   output logic [2*KMER_MAX-1:0]         cnt_rd_addr,
   input  logic [kcf_pkg::CNT_W:0]       cnt_rd_data
);

   localparam int KW     = 2 * KMER_MAX;
   localparam int HP_W   = $clog2(WINDOW_MAX);
   localparam int POS_W  = $clog2(WINDOW_MAX + 1);
   localparam int CW     = (POS_W > kcf_pkg::WLEN_W) ? POS_W : kcf_pkg::WLEN_W;
   localparam int CNT_W  = kcf_pkg::CNT_W;
   localparam int WORD_W = CNT_W + 1;

   kcf_pkg::state_type state_ff, state_in;

   logic [KW-1:0]     cur_ff, cur_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [HP_W-1:0]   hp_ff, hp_in;
   logic [KW-1:0]     kmer_ff, kmer_in;
   logic              do_dec_ff, do_dec_in;
   logic              do_inc_ff, do_inc_in;
   logic              last_ff, last_in;
   logic              report_ff, report_in;
   logic [WORD_W-1:0] new_word_ff, new_word_in;
   logic [WORD_W-1:0] kmer_word_ff, kmer_word_in;
   logic [KW-1:0]     clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0]     rsp_kmer_ff, rsp_kmer_in;
   logic              rsp_kvalid_ff, rsp_kvalid_in;
   logic              rsp_end_ff, rsp_end_in;

   // accept-side arithmetic
   logic [kcf_pkg::KLEN_W-1:0] k_eff;
   logic [KW-1:0]              kmer_mask;
   logic [KW-1:0]              cur_next;
   logic [KW-1:0]              kmer_next;
   logic [CW-1:0]              win_ext, win_eff, k_ext, span, pos_ext, hp_ext, idx_ext;
   logic                       counting, dec_next, inc_next;
   logic [POS_W-1:0]           pos_next;
   logic [HP_W-1:0]            hp_next;

   // update-side arithmetic
   logic [KW-1:0]     old_kmer;
   logic [CNT_W-1:0]  old_cnt, old_dec;
   logic              old_flag;
   logic [WORD_W-1:0] dec_word, base_word, new_word;
   logic [CNT_W-1:0]  base_cnt, inc_cnt;
   logic              base_flag, hit;
   logic              slot_free;

   always_comb begin
      if (cfg.kmer_length == '0) begin
         k_eff = kcf_pkg::KLEN_W'(1);
      end else if (cfg.kmer_length > kcf_pkg::KLEN_W'(KMER_MAX)) begin
         k_eff = kcf_pkg::KLEN_W'(KMER_MAX);
      end else begin
         k_eff = cfg.kmer_length;
      end
      kmer_mask = ~({KW{1'b1}} << {k_eff, 1'b0});
      cur_next  = KW'({cur_ff, req.base});
      kmer_next = cur_next & kmer_mask;

      win_ext  = CW'(cfg.window_length);
      win_eff  = (win_ext > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : win_ext;
      k_ext    = CW'(k_eff);
      counting = (win_eff >= k_ext);
      span     = win_eff - k_ext + CW'(1);
      pos_ext  = CW'(pos_ff);
      dec_next = counting && (pos_ext >= win_eff);
      inc_next = counting && (pos_ext >= k_ext - CW'(1));

      // slot of the k-mer leaving the window, modulo the history depth
      hp_ext = CW'(hp_ff);
      if (hp_ext >= span) begin
         idx_ext = hp_ext - span;
      end else begin
         idx_ext = hp_ext + (CW'(WINDOW_MAX) - span);
      end

      pos_next = (pos_ff < POS_W'(WINDOW_MAX)) ? pos_ff + POS_W'(1) : pos_ff;
      hp_next  = (hp_ff == HP_W'(WINDOW_MAX - 1)) ? '0 : hp_ff + HP_W'(1);
   end

   always_comb begin
      old_kmer = hist_rd_data;
      old_cnt  = cnt_rd_data[CNT_W-1:0];
      old_flag = cnt_rd_data[CNT_W];
      old_dec  = (old_cnt != '0) ? old_cnt - CNT_W'(1) : old_cnt;
      dec_word = {old_flag, old_dec};
      // leaving and entering k-mer share an entry: add on top of the decrement
      base_word = (do_dec_ff && (old_kmer == kmer_ff)) ? dec_word : kmer_word_ff;
      base_cnt  = base_word[CNT_W-1:0];
      base_flag = base_word[CNT_W];
      inc_cnt   = (do_inc_ff && !(&base_cnt)) ? base_cnt + CNT_W'(1) : base_cnt;
      hit       = do_inc_ff && (inc_cnt >= cfg.threshold) && !base_flag;
      new_word  = {base_flag | hit, inc_cnt};
   end

   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      hp_in         = hp_ff;
      kmer_in       = kmer_ff;
      do_dec_in     = do_dec_ff;
      do_inc_in     = do_inc_ff;
      last_in       = last_ff;
      report_in     = report_ff;
      new_word_in   = new_word_ff;
      kmer_word_in  = kmer_word_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_kmer_in   = rsp_kmer_ff;
      rsp_kvalid_in = rsp_kvalid_ff;
      rsp_end_in    = rsp_end_ff;

      hist_wr_en   = 1'b0;
      hist_wr_addr = hp_ff;
      hist_wr_data = kmer_ff;
      hist_rd_en   = 1'b0;
      hist_rd_addr = HP_W'(idx_ext);
      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = kmer_ff;
      cnt_wr_data  = new_word_ff;
      cnt_rd_en    = 1'b0;
      cnt_rd_addr  = kmer_next;

      unique case (state_ff)
         kcf_pkg::ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
            cnt_wr_data = '0;
            clr_in      = clr_ff + KW'(1);
            if (&clr_ff) begin
               state_in = kcf_pkg::ST_IDLE;
            end
         end
         kcf_pkg::ST_IDLE: begin
            if (req.valid) begin
               hist_rd_en = 1'b1;
               cnt_rd_en  = 1'b1;
               cur_in     = cur_next;
               kmer_in    = kmer_next;
               pos_in     = pos_next;
               do_dec_in  = dec_next;
               do_inc_in  = inc_next;
               last_in    = req.last_base;
               state_in   = kcf_pkg::ST_FETCH;
            end
         end
         kcf_pkg::ST_FETCH: begin
            // count of the entering k-mer arrives; fetch the leaving one
            kmer_word_in = cnt_rd_data;
            hist_wr_en   = 1'b1;
            hp_in        = hp_next;
            cnt_rd_en    = 1'b1;
            cnt_rd_addr  = hist_rd_data;
            state_in     = kcf_pkg::ST_UPDATE;
         end
         kcf_pkg::ST_UPDATE: begin
            cnt_wr_en   = do_dec_ff;
            cnt_wr_addr = old_kmer;
            cnt_wr_data = dec_word;
            new_word_in = new_word;
            report_in   = hit;
            state_in    = kcf_pkg::ST_COMMIT;
         end
         kcf_pkg::ST_COMMIT: begin
            cnt_wr_en = do_inc_ff;
            if (!(report_ff || last_ff) || slot_free) begin
               if (report_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kmer_in   = kmer_ff;
                  rsp_kvalid_in = 1'b1;
                  rsp_end_in    = 1'b0;
               end else if (last_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kmer_in   = '0;
                  rsp_kvalid_in = 1'b0;
                  rsp_end_in    = 1'b1;
               end
               if (last_ff) begin
                  cur_in   = '0;
                  pos_in   = '0;
                  hp_in    = '0;
                  state_in = report_ff ? kcf_pkg::ST_MARK : kcf_pkg::ST_CLEAR;
               end else begin
                  state_in = kcf_pkg::ST_IDLE;
               end
            end
         end
         kcf_pkg::ST_MARK: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kmer_in   = '0;
               rsp_kvalid_in = 1'b0;
               rsp_end_in    = 1'b1;
               state_in      = kcf_pkg::ST_CLEAR;
            end
         end
         default: begin
            state_in = kcf_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kcf_pkg::ST_CLEAR;
         cur_ff       <= '0;
         pos_ff       <= '0;
         hp_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         hp_ff        <= hp_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kmer_ff       <= kmer_in;
      do_dec_ff     <= do_dec_in;
      do_inc_ff     <= do_inc_in;
      last_ff       <= last_in;
      report_ff     <= report_in;
      new_word_ff   <= new_word_in;
      kmer_word_ff  <= kmer_word_in;
      rsp_kmer_ff   <= rsp_kmer_in;
      rsp_kvalid_ff <= rsp_kvalid_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign req.ready           = (state_ff == kcf_pkg::ST_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.clump_kmer      = rsp_kmer_ff;
   assign rsp.kmer_valid      = rsp_kvalid_ff;
   assign rsp.end_of_sequence = rsp_end_ff;

   `KCF_ASSERT_IMPL(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_W'(WINDOW_MAX))
   `KCF_ASSERT_IMPL(a_hp_range, clock, reset, 1'b1, hp_ff <= HP_W'(WINDOW_MAX - 1))
   `KCF_ASSERT_IMPL(a_rsp_kind, clock, reset, rsp_valid_ff, !(rsp_kvalid_ff && rsp_end_ff))
   `KCF_ASSERT_NEXT(a_clear_done, clock, reset, state_ff == kcf_pkg::ST_CLEAR && (&clr_ff), state_ff == kcf_pkg::ST_IDLE && clr_ff == '0)
   `KCF_ASSERT_NEXT(a_end_clears, clock, reset, state_ff == kcf_pkg::ST_COMMIT && last_ff && !report_ff && slot_free, state_ff == kcf_pkg::ST_CLEAR && pos_ff == '0)

endmodule

// ===== sv/kmer_clump_finder.sv =====
// Clump finder for a stream of 2-bit dna bases. Each accepted base passes through
// the fetch, update and commit states: the history memory is read for the k-mer
// leaving the window, then the count memory is read for it, and the single write
// port of the count memory takes the decremented leaving entry and then the
// incremented entering entry. Commit waits while a report or end marker finds the
// result register full. One result register holds a report or end marker while the
// next base is being worked. After reset, and after every base marked last_base, the
// count memory is swept clear one entry a cycle, all 4**KMER_MAX entries (262144 at the
// default), and no base is accepted during the sweep; register writes are taken at any time.
module kmer_clump_finder #(
   parameter int KMER_MAX   = kcf_pkg::KMER_MAX_DEF,
   parameter int WINDOW_MAX = kcf_pkg::WINDOW_MAX_DEF
) (
   input logic        clock,
   input logic        reset,
   kcf_csr_if.sink    csr_ch,
   kcf_req_if.sink    req_ch,
   kcf_rsp_if.source  rsp_ch
);

   localparam int KW     = 2 * KMER_MAX;
   localparam int HP_W   = $clog2(WINDOW_MAX);
   localparam int WORD_W = kcf_pkg::CNT_W + 1;

   kcf_pkg::cfg_type cfg;

   logic              hist_wr_en;
   logic [HP_W-1:0]   hist_wr_addr;
   logic [KW-1:0]     hist_wr_data;
   logic              hist_rd_en;
   logic [HP_W-1:0]   hist_rd_addr;
   logic [KW-1:0]     hist_rd_data;
   logic              cnt_wr_en;
   logic [KW-1:0]     cnt_wr_addr;
   logic [WORD_W-1:0] cnt_wr_data;
   logic              cnt_rd_en;
   logic [KW-1:0]     cnt_rd_addr;
   logic [WORD_W-1:0] cnt_rd_data;

   kcf_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // k-mers in order of arrival, one per window position
   kcf_ram #(
      .WIDTH (KW),
      .DEPTH (WINDOW_MAX)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // per k-mer word: reported flag over window count
   kcf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (1 << KW)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   kcf_ctrl #(
      .KMER_MAX   (KMER_MAX),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .hist_wr_en   (hist_wr_en),
      .hist_wr_addr (hist_wr_addr),
      .hist_wr_data (hist_wr_data),
      .hist_rd_en   (hist_rd_en),
      .hist_rd_addr (hist_rd_addr),
      .hist_rd_data (hist_rd_data),
      .cnt_wr_en    (cnt_wr_en),
      .cnt_wr_addr  (cnt_wr_addr),
      .cnt_wr_data  (cnt_wr_data),
      .cnt_rd_en    (cnt_rd_en),
      .cnt_rd_addr  (cnt_rd_addr),
      .cnt_rd_data  (cnt_rd_data)
   );

endmodule

// ===== sim/tb_kmer_clump_finder.sv =====
// testbench for kmer_clump_finder: drives bases and register writes, predicts
// clump reports and end markers, and checks every result item in order
// depends on kcf_pkg, kcf_req_if, kcf_rsp_if, kcf_csr_if and the block itself
module tb_kmer_clump_finder;

   localparam int          KMER_MAX       = kcf_pkg::KMER_MAX_DEF;
   localparam int          WINDOW_MAX     = kcf_pkg::WINDOW_MAX_DEF;
   localparam int          TABLE_SIZE     = 1 << (2 * KMER_MAX);
   localparam logic [10:0] COUNT_MAX      = 11'd2047;
   localparam int          RANDOM_ITEMS   = 1040;
   localparam int          SETTLE_CYCLES  = 12;
   localparam int          WATCHDOG_LIMIT = 800000;

   typedef struct packed {
      logic [2*KMER_MAX-1:0] kmer;
      logic                  hit;
      logic                  eos;
   } clump_rsp_type;

   class clump_scoreboard_type;
      logic [kcf_pkg::KLEN_W-1:0] kmer_len;
      logic [kcf_pkg::WLEN_W-1:0] win_len;
      logic [kcf_pkg::THR_W-1:0]  thresh;
      logic [2*KMER_MAX-1:0]      shift_kmer;
      int unsigned                seen;
      logic [kcf_pkg::CNT_W-1:0]  occ [TABLE_SIZE];
      bit                         flagged [TABLE_SIZE];
      logic [2*KMER_MAX-1:0]      trail [WINDOW_MAX];
      int unsigned                trail_ptr;
      clump_rsp_type              pending [$];
      int                         errors;

      function new();
         kmer_len = kcf_pkg::KLEN_RESET;
         win_len  = kcf_pkg::WLEN_RESET;
         thresh   = kcf_pkg::THR_RESET;
         errors   = 0;
         clear_seq();
      endfunction

      function void clear_seq();
         shift_kmer = '0;
         seen       = 0;
         trail_ptr  = 0;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            occ[i]     = '0;
            flagged[i] = 1'b0;
         end
      endfunction

      function void add_expected(clump_rsp_type item);
         pending.insert(pending.size(), item);
      endfunction

      function void set_reg(kcf_pkg::csr_idx_type idx, logic [kcf_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            kcf_pkg::CSR_KMER_LENGTH:   kmer_len = val[kcf_pkg::KLEN_W-1:0];
            kcf_pkg::CSR_WINDOW_LENGTH: win_len  = val[kcf_pkg::WLEN_W-1:0];
            kcf_pkg::CSR_THRESHOLD:     thresh   = val[kcf_pkg::THR_W-1:0];
            default: ;
         endcase
      endfunction

      // leaving k-mer is taken out before the entering one is counted
      function void note_base(logic [1:0] b, logic lb);
         int unsigned           k, w, span, slot;
         logic [2*KMER_MAX-1:0] mask, cur, gone;
         k = (kmer_len == 0) ? 1 : ((kmer_len > KMER_MAX) ? KMER_MAX : kmer_len);
         w = (win_len > WINDOW_MAX) ? WINDOW_MAX : win_len;
         mask = (2*KMER_MAX)'((32'd1 << (2 * k)) - 32'd1);
         shift_kmer = {shift_kmer[2*KMER_MAX-3:0], b};
         cur = shift_kmer & mask;
         if (w >= k) begin
            span = w - k + 1;
            if (seen >= w) begin
               slot = (trail_ptr + WINDOW_MAX - span) % WINDOW_MAX;
               gone = trail[slot];
               if (occ[gone] != 0) occ[gone]--;
            end
            if (seen + 1 >= k) begin
               if (occ[cur] != COUNT_MAX) occ[cur]++;
               if (occ[cur] >= thresh && !flagged[cur]) begin
                  flagged[cur] = 1'b1;
                  add_expected('{kmer: cur, hit: 1'b1, eos: 1'b0});
               end
            end
         end
         trail[trail_ptr] = cur;
         trail_ptr = (trail_ptr + 1) % WINDOW_MAX;
         if (seen < WINDOW_MAX) seen++;
         if (lb) begin
            add_expected('{kmer: '0, hit: 1'b0, eos: 1'b1});
            clear_seq();
         end
      endfunction

      function void check_result(logic [2*KMER_MAX-1:0] kmer, logic hit, logic eos);
         clump_rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: expected none, actual kmer %h valid %b eos %b",
                     $time, kmer, hit, eos);
            return;
         end
         want = pending.pop_front();
         if (kmer !== want.kmer) begin
            errors++;
            $display("%0t: clump_kmer mismatch: expected %h, actual %h", $time, want.kmer, kmer);
         end
         if (hit !== want.hit) begin
            errors++;
            $display("%0t: kmer_valid mismatch: expected %b, actual %b", $time, want.hit, hit);
         end
         if (eos !== want.eos) begin
            errors++;
            $display("%0t: end_of_sequence mismatch: expected %b, actual %b",
                     $time, want.eos, eos);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_on;
   int   quiet;

   clump_scoreboard_type board;

   kcf_req_if req_ch ();
   kcf_rsp_if rsp_ch ();
   kcf_csr_if csr_ch ();

   kmer_clump_finder i_dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch.sink),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result checking and the no-progress watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.clump_kmer, rsp_ch.kmer_valid, rsp_ch.end_of_sequence);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet <= 0;
         end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, quiet);
            $display("DONE: errors detected");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   // receiver stalls in short bursts
   initial begin
      int hold;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(1, 6);
            rsp_ch.ready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
      end
   end

   // called and left at a falling edge
   task automatic send_base(input logic [1:0] b, input logic lb);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.base      = b;
      req_ch.last_base = lb;
      do @(posedge clock); while (!req_ch.ready);
      board.note_base(b, lb);
      @(negedge clock);
   endtask

   task automatic write_reg(input kcf_pkg::csr_idx_type idx,
                            input logic [kcf_pkg::CSR_DATA_W-1:0] val);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = val;
      do @(posedge clock); while (!csr_ch.ready);
      board.set_reg(idx, val);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic write_config(input logic [kcf_pkg::CSR_DATA_W-1:0] k, input logic [10:0] w,
                               input logic [10:0] t);
      write_reg(kcf_pkg::CSR_KMER_LENGTH, k);
      write_reg(kcf_pkg::CSR_WINDOW_LENGTH, w);
      write_reg(kcf_pkg::CSR_THRESHOLD, t);
   endtask

   // bases packed two bits each, first base in the highest used pair
   task automatic send_packed(input logic [31:0] bases, input int n, input logic end_seq);
      for (int i = n - 1; i >= 0; i--)
         send_base(bases[2*i +: 2], end_seq && i == 0);
   endtask

   // no item may cause no result and still be in flight when a register changes
   task automatic drain();
      req_ch.valid = 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned           done_items, len, mlen, step;
      logic [3:0]            k;
      logic [10:0]           w, t;
      logic [1:0]            motif [6];
      logic [1:0]            b;
      logic                  lb;
      bit                    final_phase;

      board            = new();
      reset            = 1'b1;
      idle_on          = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.base      = 2'd0;
      req_ch.last_base = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = kcf_pkg::CSR_KMER_LENGTH;
      csr_ch.data      = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-base k-mers, tiny window: A A C G T T C C
      write_config(11'd1, 11'd4, 11'd2);
      send_packed(32'h06F5, 8, 1'b0);
      drain();
      // k of zero, window above the maximum, threshold zero: G C A
      write_config(11'd0, 11'd2047, 11'd0);
      send_packed(32'h24, 3, 1'b0);
      drain();
      // k above the maximum and window shorter than k: T T T T
      write_config(11'd15, 11'd3, 11'd1);
      send_packed(32'hFF, 4, 1'b0);
      drain();
      // last base that also reports: C G T
      write_config(11'd2, 11'd8, 11'd1);
      send_packed(32'h1B, 3, 1'b1);
      drain();

      // one long sequence in phases of random settings, changed mid-sequence
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         final_phase = (RANDOM_ITEMS - done_items) <= 150;
         len = final_phase ? RANDOM_ITEMS - done_items : $urandom_range(20, 120);
         if (final_phase) begin
            // window at and above the maximum; the sequence fills it during this phase
            k = 4'($urandom_range(1, 3));
            w = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
            t = 11'($urandom_range(2, 8));
         end else if ($urandom_range(0, 3) == 0) begin
            k = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 5))
               0: w = 11'd0;
               1: w = 11'd1;
               2: w = 11'd1023;
               3: w = 11'd1025;
               4: w = 11'd2047;
               default: w = 11'($urandom_range(0, 2047));
            endcase
            case ($urandom_range(0, 4))
               0: t = 11'd0;
               1: t = 11'd1024;
               2: t = 11'd2047;
               default: t = 11'($urandom_range(0, 2047));
            endcase
         end else begin
            k = 4'($urandom_range(1, 6));
            w = 11'($urandom_range(k, 64));
            t = 11'($urandom_range(1, 4));
         end
         write_config({7'($urandom), k}, w, t);
         idle_on = !final_phase && $urandom_range(0, 3) != 0;
         mlen = $urandom_range(1, 6);
         for (int i = 0; i < 6; i++) motif[i] = 2'($urandom_range(0, 3));
         step = 0;
         for (int unsigned i = 0; i < len; i++) begin
            // mostly a repeated motif so k-mers recur within the window
            if ($urandom_range(0, 3) == 0) begin
               b = 2'($urandom_range(0, 3));
            end else begin
               b = motif[step % mlen];
               step++;
            end
            lb = final_phase && i == len - 1;
            send_base(b, lb);
         end
         done_items += len;
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== kmer_clump_finder.f =====
+incdir+sv
sv/kcf_pkg.sv
sv/kcf_req_if.sv
sv/kcf_rsp_if.sv
sv/kcf_csr_if.sv
sv/kcf_ram.sv
sv/kcf_csr.sv
sv/kcf_ctrl.sv
sv/kmer_clump_finder.sv
sim/tb_kmer_clump_finder.sv
